// ----- hw/rtl/obdrp_pkg.sv -----
// obdrp_pkg: types, codes and character helpers for the OBD ASCII response parser.
// No dependencies; imported by every module of the parser.
package obdrp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

  localparam logic [7:0] PID_RST   = 8'd0;
  localparam logic [7:0] LIMIT_RST = 8'd40;

  // Result kinds and end status codes
  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_END    = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Characters
  localparam logic [7:0] CH_PROMPT = 8'h3E;  // '>'
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CH_MODE   = 8'h34;  // '4'
  localparam logic [7:0] CH_SVC    = 8'h31;  // '1'

  // Header layout
  localparam logic [7:0] POS_MODE   = 8'd0;
  localparam logic [7:0] POS_SVC    = 8'd1;
  localparam logic [7:0] POS_PID_HI = 8'd3;
  localparam logic [7:0] POS_PID_LO = 8'd4;
  localparam logic [7:0] HDR_LEN    = 8'd5;
  localparam logic [7:0] DATA_POS   = 8'd6;

  // Token digit count saturates one above the byte-safe length
  localparam logic [3:0] TOK_MAX_DIG = 4'd8;
  localparam logic [3:0] TOK_SAT_DIG = 4'd9;

  // Result queue
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } res_t;

  // Results caused by one accepted character, in order
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } step_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] cnt;
  } qstat_t;

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [7:0] hex_upper(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'h0, n};
    end else begin
      c = 8'h37 + {4'h0, n};
    end
    return c;
  endfunction

  // {is_hex, value}; upper and lower case letters accepted
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/obdrp_if.sv -----
// obdrp_if: valid/ready channel interfaces for received characters and results.
// No dependencies.
interface obdrp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface obdrp_result_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_kind, output data_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input out_kind, input data_byte, input status,
                  input last, output ready);
endinterface

// ----- hw/rtl/obd_ascii_response_parser_core.sv -----
// obd_ascii_response_parser_core: parses the ASCII reply to a mode 01 request.
// Order: the results of an accepted character are written into the result queue and
//   offered from its head after any already waiting; a second result follows the first.
// Throughput: one character per cycle; a character may add two results, and the
//   four-entry result queue holds ready low while more than two results wait.
// Reset: pid_code 0, line_limit 40, response state cleared, result queue empty.
module obd_ascii_response_parser_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [obdrp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                      cfg_wdata_i,
  obdrp_char_if.sink                      rx_i,
  obdrp_result_if.source                  res_o
);
  import obdrp_pkg::*;

  logic   rx_acc;
  logic   q_ready, q_valid, pop;
  step_t  step;
  res_t   head;
  qstat_t q_stat;

  // Accept a character request whenever the queue can absorb a worst-case pair
  assign rx_i.ready = q_ready;
  assign rx_acc     = rx_i.valid & q_ready;

  // Decode the character against the running response state; results leave
  // as a step, zero, one or two of them, in model order.
  obdrp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .char_vld_i  (rx_acc),
    .char_i      (rx_i.rx_char),
    .step_o      (step)
  );

  // Hold results until the downstream side takes them
  assign pop = q_valid & res_o.ready;

  obdrp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .pop_i   (pop),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  assign res_o.valid     = q_valid;
  assign res_o.out_kind  = head.kind;
  assign res_o.data_byte = head.data;
  assign res_o.status    = head.status;
  assign res_o.last      = head.last;

`ifndef SYNTHESIS
  // Queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.cnt <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overfilled");

  // A second result only follows a first, and it is always the end result
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.v1 |-> (step.v0 && step.r1.kind == KIND_END && step.r1.last && !step.r0.last))
    else $error("bad result pair");

  // A lone result closes its character
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.v0 && !step.v1) |-> step.r0.last)
    else $error("single result without last");

  // Results are only produced for an accepted character
  a_step_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.v0 |-> rx_acc)
    else $error("result without accepted character");
`endif

endmodule

// ----- hw/rtl/obdrp_parse.sv -----
// obdrp_parse: configuration registers, response state and per-character decode.
// Depends on obdrp_pkg.
module obdrp_parse (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [obdrp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [7:0]                       cfg_wdata_i,
  input  logic                             char_vld_i,
  input  logic [7:0]                       char_i,
  output obdrp_pkg::step_t                 step_o
);
  import obdrp_pkg::*;

  logic [7:0] pid_q, limit_q;
  logic [7:0] pos_q, pos_d;
  logic       hbad_q, hbad_d;
  logic [7:0] tval_q, tval_d;
  logic [3:0] tdig_q, tdig_d;
  logic       dstop_q, dstop_d;

  logic       hb;
  logic [7:0] tok_byte;
  logic [4:0] hv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q   <= PID_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PID:   pid_q   <= cfg_wdata_i;
        CFG_LIMIT: limit_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    pos_d    = pos_q;
    hbad_d   = hbad_q;
    tval_d   = tval_q;
    tdig_d   = tdig_q;
    dstop_d  = dstop_q;
    step_o   = '0;
    hb       = hbad_q;
    hv       = hex_val(char_i);
    tok_byte = (tdig_q > TOK_MAX_DIG) ? 8'hFF : tval_q;

    if (char_vld_i) begin
      if (pos_q >= limit_q) begin
        // drop the character, end with overflow
        step_o.v0 = 1'b1;
        step_o.r0 = '{kind: KIND_END, data: 8'h00, status: ST_OVERFLOW, last: 1'b1};
        pos_d = '0; hbad_d = 1'b0; tval_d = '0; tdig_d = '0; dstop_d = 1'b0;
      end else if (char_i == CH_PROMPT) begin
        hb = hbad_q | (pos_q < HDR_LEN);
        if (!hb && !dstop_q && (tdig_q != 4'd0)) begin
          step_o.v0 = 1'b1;
          step_o.r0 = '{kind: KIND_DATA, data: tok_byte, status: ST_OK, last: 1'b0};
          step_o.v1 = 1'b1;
          step_o.r1 = '{kind: KIND_END, data: 8'h00, status: ST_OK, last: 1'b1};
        end else begin
          step_o.v0 = 1'b1;
          step_o.r0 = '{kind: KIND_END, data: 8'h00,
                        status: (hb ? ST_MISMATCH : ST_OK), last: 1'b1};
        end
        pos_d = '0; hbad_d = 1'b0; tval_d = '0; tdig_d = '0; dstop_d = 1'b0;
      end else if (char_i >= CH_SPACE) begin
        case (pos_q)
          POS_MODE:   hb = hbad_q | (char_i != CH_MODE);
          POS_SVC:    hb = hbad_q | (char_i != CH_SVC);
          POS_PID_HI: hb = hbad_q | (char_i != hex_upper(pid_q[7:4]));
          POS_PID_LO: hb = hbad_q | (char_i != hex_upper(pid_q[3:0]));
          default:    hb = hbad_q;
        endcase
        hbad_d = hb;
        if ((pos_q >= DATA_POS) && !hb && !dstop_q) begin
          if (hv[4]) begin
            tval_d = {tval_q[3:0], hv[3:0]};
            if (tdig_q < TOK_SAT_DIG) begin
              tdig_d = tdig_q + 4'd1;
            end
          end else begin
            // space ends a token; anything else ends the data too
            if (tdig_q != 4'd0) begin
              step_o.v0 = 1'b1;
              step_o.r0 = '{kind: KIND_DATA, data: tok_byte, status: ST_OK, last: 1'b1};
              tval_d = '0;
              tdig_d = '0;
            end
            if (char_i != CH_SPACE) begin
              dstop_d = 1'b1;
            end
          end
        end
        pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hbad_q  <= 1'b0;
      tval_q  <= '0;
      tdig_q  <= '0;
      dstop_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      hbad_q  <= hbad_d;
      tval_q  <= tval_d;
      tdig_q  <= tdig_d;
      dstop_q <= dstop_d;
    end
  end

endmodule

// ----- hw/rtl/obdrp_outq.sv -----
// obdrp_outq: small result queue taking up to two results per cycle, giving one.
// Depends on obdrp_pkg.
module obdrp_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  obdrp_pkg::step_t  step_i,
  input  logic              pop_i,
  output logic              ready_o,
  output logic              valid_o,
  output obdrp_pkg::res_t   head_o,
  output obdrp_pkg::qstat_t stat_o
);
  import obdrp_pkg::*;

  res_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  assign valid_o    = (cnt_q != '0);
  assign ready_o    = (cnt_q <= Q_CNT_W'(Q_DEPTH - 2));
  assign head_o     = mem_q[rp_q];
  assign stat_o.cnt = cnt_q;

  always_comb begin
    wp_d  = wp_q + Q_PTR_W'(step_i.v0) + Q_PTR_W'(step_i.v1);
    rp_d  = rp_q + Q_PTR_W'(pop_i);
    cnt_d = cnt_q + Q_CNT_W'(step_i.v0) + Q_CNT_W'(step_i.v1) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (step_i.v0) begin
      mem_q[wp_q] <= step_i.r0;
    end
    if (step_i.v1) begin
      mem_q[wp_q + Q_PTR_W'(1)] <= step_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for obd_ascii_response_parser_core.
// Depends on obdrp_pkg and the obdrp_char_if / obdrp_result_if channel interfaces.
module testbench;
  import obdrp_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_CHARS  = 100;
  localparam int unsigned LONG_HOLD    = 300;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_PID;
  logic [7:0]           cfg_wdata = 8'h00;

  obdrp_char_if   rx_if ();
  obdrp_result_if res_if ();

  obd_ascii_response_parser_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies, updated when the write lands in the block.
  logic [7:0] pid_reg   = PID_RST;
  logic [7:0] limit_reg = LIMIT_RST;

  // Parser state of the current response line.
  logic [7:0] line_pos = 8'd0;
  logic       hdr_bad  = 1'b0;
  logic [7:0] tok_val  = 8'd0;
  logic [3:0] tok_dig  = 4'd0;
  logic       data_off = 1'b0;

  res_t       parsed_q [$];  // results the parser owes, oldest first
  logic [7:0] char_q   [$];  // characters waiting to be offered

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          send_hold      = 1'b0;
  int unsigned hold_left      = 0;

  int unsigned chars_queued = 0;
  int unsigned chars_sent   = 0;
  int unsigned data_seen    = 0;
  int unsigned ends_seen    = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  res_t        got_res;
  res_t        want_res;

  // ---------------------------------------------------------------------------
  // Character helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (lower ? 8'h57 : 8'h37) + {4'h0, n};
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    if (c <= "9") return 4'(c - 8'h30);
    if (c <= "F") return 4'(c - 8'h37);
    return 4'(c - 8'h57);
  endfunction

  // ---------------------------------------------------------------------------
  // Response parser prediction: one accepted character in, owed results out.
  // ---------------------------------------------------------------------------
  function automatic void add_result(input logic kind, input logic [7:0] data,
                                     input logic [1:0] st);
    res_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = st;
    r.last   = 1'b0;
    parsed_q.push_back(r);
  endfunction

  function automatic void reset_line();
    line_pos = 8'd0;
    hdr_bad  = 1'b0;
    tok_val  = 8'd0;
    tok_dig  = 4'd0;
    data_off = 1'b0;
  endfunction

  // Emit the token being read, if any; a token past eight digits saturates.
  function automatic int flush_token();
    if (tok_dig == 4'd0) return 0;
    add_result(KIND_DATA, (tok_dig > TOK_MAX_DIG) ? 8'hFF : tok_val, ST_OK);
    tok_val = 8'd0;
    tok_dig = 4'd0;
    return 1;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    int n;
    n = 0;
    if (line_pos >= limit_reg) begin
      // Line full: drop this character whatever it is, close as overflow.
      add_result(KIND_END, 8'h00, ST_OVERFLOW);
      n = 1;
      reset_line();
    end else if (c == CH_PROMPT) begin
      // Prompt closes the response; a reply shorter than the header fails.
      if (line_pos < HDR_LEN) hdr_bad = 1'b1;
      if (!hdr_bad && !data_off) n += flush_token();
      add_result(KIND_END, 8'h00, hdr_bad ? ST_MISMATCH : ST_OK);
      n++;
      reset_line();
    end else if (c >= CH_SPACE) begin
      case (line_pos)
        POS_MODE:   if (c != CH_MODE) hdr_bad = 1'b1;
        POS_SVC:    if (c != CH_SVC) hdr_bad = 1'b1;
        POS_PID_HI: if (c != hex_char(pid_reg[7:4], 1'b0)) hdr_bad = 1'b1;
        POS_PID_LO: if (c != hex_char(pid_reg[3:0], 1'b0)) hdr_bad = 1'b1;
        default: ;
      endcase
      if (line_pos >= DATA_POS && !hdr_bad && !data_off) begin
        if (is_hex(c)) begin
          tok_val = {tok_val[3:0], hex_nib(c)};
          if (tok_dig < TOK_SAT_DIG) tok_dig++;
        end else begin
          // Space ends a token; anything else ends the data for good.
          n += flush_token();
          if (c != CH_SPACE) data_off = 1'b1;
        end
      end
      line_pos++;
    end
    // Control characters below space fall through with nothing owed.
    if (n > 0) parsed_q[parsed_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  // Queue one character; noisy lines sometimes carry a stray control code first.
  function automatic void put(input logic [7:0] c, input bit noisy);
    if (noisy && $urandom_range(99) < 3) begin
      char_q.push_back(8'($urandom_range(31)));
      chars_queued++;
    end
    char_q.push_back(c);
    chars_queued++;
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (is_hex(c) || c == CH_PROMPT);
    return c;
  endfunction

  // One adapter reply: mostly well formed with random payload, the rest
  // bad headers, short replies and raw line noise.
  function automatic void gen_reply();
    logic [7:0] hdr [5];
    int pick, ntok, nd, cut, p, r;
    pick = $urandom_range(99);
    if (pick >= 85) begin
      // Line noise: any byte value, usually closed by a prompt.
      repeat ($urandom_range(1, 12)) put(8'($urandom_range(255)), 1'b0);
      if ($urandom_range(9) != 0) put(CH_PROMPT, 1'b0);
      return;
    end
    hdr[0] = CH_MODE;
    hdr[1] = CH_SVC;
    hdr[2] = CH_SPACE;
    hdr[3] = hex_char(pid_reg[7:4], 1'b0);
    hdr[4] = hex_char(pid_reg[3:0], 1'b0);
    if (pick >= 70) begin
      // Flip one bit of one header character.
      p = $urandom_range(4);
      hdr[p] = hdr[p] ^ 8'(1 << $urandom_range(7));
    end
    cut = (pick >= 62 && pick < 70) ? $urandom_range(4) : 5;
    for (int i = 0; i < cut; i++) put(hdr[i], 1'b1);
    if (cut < 5) begin
      put(CH_PROMPT, 1'b1);
      return;
    end
    // The separator after the PID is never data; vary it now and then.
    put(($urandom_range(9) == 0) ? non_hex() : CH_SPACE, 1'b1);
    ntok = $urandom_range(0, 6);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat (($urandom_range(9) == 0) ? 3 : 1) put(CH_SPACE, 1'b1);
      if ($urandom_range(24) == 0) put(non_hex(), 1'b1);
      r  = $urandom_range(99);
      nd = (r < 70) ? 2 : (r < 84) ? 1 : (r < 95) ? $urandom_range(3, 8)
                                                  : $urandom_range(9, 12);
      repeat (nd) put(hex_char(4'($urandom_range(15)), $urandom_range(3) == 0), 1'b1);
    end
    repeat ($urandom_range(0, 2)) put(CH_SPACE, 1'b1);
    if ($urandom_range(1) == 1) put(8'h0D, 1'b1);
    put(CH_PROMPT, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Phase control
  // ---------------------------------------------------------------------------
  // Wait for the block to go quiet: nothing queued, nothing offered, nothing
  // owed, then let a character still in flight that owes nothing pass through.
  task automatic settle();
    while (char_q.size() != 0 || rx_if.valid || parsed_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PID) pid_reg = val;
    else limit_reg = val;
  endtask

  task automatic run_phase(input logic [7:0] pid, input logic [7:0] limit,
                           input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned start;
    write_reg(CFG_PID, pid);
    write_reg(CFG_LIMIT, limit);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = chars_queued;
    while (chars_queued - start < PHASE_CHARS) gen_reply();
  endtask

  // ---------------------------------------------------------------------------
  // Character driver: offer the next queued character when the last request
  // has gone through, and feed every accepted one to the prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_char <= 8'h00;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        parse_char(rx_if.rx_char);
        chars_sent++;
      end
      // Hold a pending request until it is taken; decide once per edge.
      if (!rx_if.valid || rx_if.ready) begin
        if (char_q.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_char <= char_q.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down on its own.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each taken result with the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_res.kind   = res_if.out_kind;
        got_res.data   = res_if.data_byte;
        got_res.status = res_if.status;
        got_res.last   = res_if.last;
        if (got_res.kind === KIND_END) ends_seen++;
        else data_seen++;
        if (parsed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: kind %0d data %02h status %0d last %0d",
                     got_res.kind, got_res.data, got_res.status, got_res.last);
        end else begin
          want_res = parsed_q.pop_front();
          if (got_res.kind !== want_res.kind || got_res.data !== want_res.data ||
              got_res.status !== want_res.status || got_res.last !== want_res.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: expected kind %0d data %02h status %0d last %0d, %s",
                       want_res.kind, want_res.data, want_res.status, want_res.last,
                       $sformatf("got kind %0d data %02h status %0d last %0d",
                                 got_res.kind, got_res.data, got_res.status,
                                 got_res.last));
          end
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hard stop in case the block wedges.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
               parsed_q.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin
    rx_if.valid   = 1'b0;
    rx_if.rx_char = 8'h00;
    res_if.ready  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed replies at reset settings (PID 00, 40-character line).
    // Full header with junk at the unchecked slots, a nine-plus digit token,
    // mixed-case digits, a run of spaces, then a non-hex stop with a
    // null byte and a carriage return that must be skipped.
    put_str("41");
    put(8'hFF, 1'b0);
    put_str("00x1ffffffff0 aB  zQ");
    put(8'h00, 1'b0);
    put(8'h0D, 1'b0);
    put(CH_PROMPT, 1'b0);
    // Prompt before the header is complete.
    put_str("4>");
    // Token closed directly by the prompt.
    put_str("41 00 7F>");
    settle();

    // Shortest line: the ninth character is dropped and closes as overflow.
    write_reg(CFG_LIMIT, 8'd8);
    @(negedge clk);
    put_str("41 00 12345>");
    settle();

    // Random phases across register settings and idling patterns.
    run_phase(8'($urandom_range(255)), 8'($urandom_range(24, 60)), 0, 0);
    settle();

    run_phase(8'hFF, 8'd16, 52, 0);
    // Stop the sender halfway and let every owed result drain.
    while (char_q.size() > PHASE_CHARS / 2) @(negedge clk);
    send_hold = 1'b1;
    while (rx_if.valid || parsed_q.size() != 0) @(negedge clk);
    send_hold = 1'b0;
    settle();

    run_phase(8'($urandom_range(255)), LIMIT_RST, 0, 52);
    // Block the result side while characters keep coming so the queue fills.
    hold_left = LONG_HOLD;
    settle();

    run_phase(8'($urandom_range(255)), 8'd255, 7, 7);
    settle();

    run_phase(8'h00, 8'd8, 0, 0);
    settle();

    mismatches += parsed_q.size();
    $display("run: %0d characters accepted, %0d data bytes and %0d response ends checked",
             chars_sent, data_seen, ends_seen);
    $display("run: PID 00/FF/random, line limits 8 to 255, stalls and a %0d-cycle hold-off",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/obdrp_pkg.sv
hw/rtl/obdrp_if.sv
hw/rtl/obdrp_parse.sv
hw/rtl/obdrp_outq.sv
hw/rtl/obd_ascii_response_parser_core.sv
dv/testbench.sv
